FILE: rtl/core/spc_pkg.sv
// Shared types, codes and widths for the stepper position controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package spc_pkg;

    // fixed field widths
    localparam int CMD_W       = 3;
    localparam int VALUE_W     = 16;
    localparam int PERIOD_W    = 8;
    localparam int COUNTDOWN_W = 17;
    localparam int POS_OUT_W   = 16;
    localparam int LEVEL_W     = 4;
    localparam int STEP_W      = 2;
    localparam int ENTRY_W     = CMD_W + VALUE_W;

    // defaults for the top-level parameters
    localparam int QUEUE_DEPTH_DEF   = 8;
    localparam int POSITION_BITS_DEF = 16;
    localparam int WAIT_BITS_DEF     = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd20;

    // item kinds on tuser
    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GOTO  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WAIT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SPEED = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CAL   = 3'd4;

    // step codes
    localparam logic [STEP_W-1:0] STEP_NONE  = 2'd0;
    localparam logic [STEP_W-1:0] STEP_LEFT  = 2'd1;
    localparam logic [STEP_W-1:0] STEP_RIGHT = 2'd2;

    typedef enum logic [1:0] {
        MODE_CAL  = 2'd0,
        MODE_IDLE = 2'd1,
        MODE_MOVE = 2'd2
    } spc_mode_t;

    // push/pop request from the controller to the command queue
    typedef struct packed {
        logic               push;
        logic               pop;
        logic [CMD_W-1:0]   op;
        logic [VALUE_W-1:0] value;
    } spc_fifo_ctl_t;

    // one result item, before packing onto tdata
    typedef struct packed {
        logic [STEP_W-1:0]    step;
        logic [POS_OUT_W-1:0] position;
        spc_mode_t            mode;
        logic                 rejected;
        logic [LEVEL_W-1:0]   level;
    } spc_result_t;

endpackage

FILE: rtl/core/spc_fifo.sv
// Command queue: circular buffer with a registered head read and write bypass.
// Depends on spc_pkg.
`timescale 1ns / 1ps

module spc_fifo #(
    parameter int QUEUE_DEPTH = spc_pkg::QUEUE_DEPTH_DEF,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  spc_pkg::spc_fifo_ctl_t      ctl,
    output logic                        empty,
    output logic                        full,
    output logic [spc_pkg::CMD_W-1:0]   head_op,
    output logic [spc_pkg::VALUE_W-1:0] head_value,
    output logic [CW-1:0]               level_next
);
    import spc_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] head_data_reg;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg;
    logic [ENTRY_W-1:0] wr_entry;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign wr_entry = {ctl.op, ctl.value};

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        level_next = count_reg;
        if (ctl.push)
        begin
            tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + AW'(1);
            level_next = count_reg + CW'(1);
        end
        else if (ctl.pop)
        begin
            head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
            level_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= level_next;
        end
    end

    // storage and registered head read; a push into the slot about to be
    // read is forwarded
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_reg] <= wr_entry;
        end
        if (ctl.push && (tail_reg == head_next))
        begin
            head_data_reg <= wr_entry;
        end
        else
        begin
            head_data_reg <= mem[head_next];
        end
    end

    assign head_op    = head_data_reg[ENTRY_W-1:VALUE_W];
    assign head_value = head_data_reg[VALUE_W-1:0];

endmodule

FILE: rtl/core/spc_ctrl.sv
// Controller state (mode, position, target, period, pace countdown) and the
// per-item update logic; drives the command queue. Depends on spc_pkg, spc_fifo.
`timescale 1ns / 1ps

module spc_ctrl #(
    parameter int QUEUE_DEPTH   = spc_pkg::QUEUE_DEPTH_DEF,
    parameter int POSITION_BITS = spc_pkg::POSITION_BITS_DEF,
    parameter int WAIT_BITS     = spc_pkg::WAIT_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic [spc_pkg::CMD_W-1:0]    cmd,
    input  logic [spc_pkg::VALUE_W-1:0]  value,
    input  logic                         detector_active,
    input  logic                         cfg_we,
    input  logic [spc_pkg::PERIOD_W-1:0] cfg_period,
    output spc_pkg::spc_result_t         result
);
    import spc_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [VALUE_W-1:0] WAIT_MASK =
        (WAIT_BITS >= VALUE_W) ? {VALUE_W{1'b1}} : VALUE_W'((32'd1 << WAIT_BITS) - 32'd1);

    spc_mode_t                mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] target_reg, target_next;
    logic [PERIOD_W-1:0]      period_reg, period_next;
    logic [COUNTDOWN_W-1:0]   countdown_reg, countdown_next;

    spc_fifo_ctl_t      fifo_ctl;
    logic               fifo_empty;
    logic               fifo_full;
    logic [CMD_W-1:0]   head_op;
    logic [VALUE_W-1:0] head_value;
    logic [CW-1:0]      level_next;

    logic [STEP_W-1:0]  step;
    logic               rejected;
    logic [VALUE_W-1:0] extra;
    logic [PERIOD_W-1:0] period_eff;

    spc_fifo #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (fifo_ctl),
        .empty     (fifo_empty),
        .full      (fifo_full),
        .head_op   (head_op),
        .head_value(head_value),
        .level_next(level_next)
    );

    always_comb
    begin
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        target_next    = target_reg;
        period_next    = period_reg;
        countdown_next = countdown_reg;
        step           = STEP_NONE;
        rejected       = 1'b0;
        extra          = '0;
        period_eff     = '0;
        fifo_ctl.push  = 1'b0;
        fifo_ctl.pop   = 1'b0;
        fifo_ctl.op    = cmd;
        fifo_ctl.value = value;

        if (fire)
        begin
            case (cmd)
                CMD_TICK:
                begin
                    if (countdown_reg != '0)
                    begin
                        countdown_next = countdown_reg - COUNTDOWN_W'(1);
                    end
                    else
                    begin
                        case (mode_reg)
                            MODE_CAL:
                            begin
                                if (!detector_active)
                                begin
                                    step = STEP_LEFT;
                                end
                                else
                                begin
                                    pos_next  = '0;
                                    mode_next = MODE_IDLE;
                                end
                            end
                            MODE_MOVE:
                            begin
                                if (pos_reg < target_reg)
                                begin
                                    step     = STEP_RIGHT;
                                    pos_next = pos_reg + POSITION_BITS'(1);
                                end
                                else if (pos_reg > target_reg)
                                begin
                                    step     = STEP_LEFT;
                                    pos_next = pos_reg - POSITION_BITS'(1);
                                end
                                else
                                begin
                                    mode_next = MODE_IDLE;
                                end
                            end
                            default:
                            begin
                                // idle: take one queued command
                                mode_next = MODE_IDLE;
                                if (!fifo_empty)
                                begin
                                    fifo_ctl.pop = 1'b1;
                                    case (head_op)
                                        CMD_GOTO:
                                        begin
                                            target_next = POSITION_BITS'(48'(head_value));
                                            mode_next   = MODE_MOVE;
                                        end
                                        CMD_WAIT:  extra       = head_value & WAIT_MASK;
                                        CMD_SPEED: period_next = head_value[PERIOD_W-1:0];
                                        CMD_CAL:   mode_next   = MODE_CAL;
                                        default:   ;
                                    endcase
                                end
                            end
                        endcase
                        period_eff     = (period_next == '0) ? PERIOD_W'(1) : period_next;
                        countdown_next = COUNTDOWN_W'(period_eff - PERIOD_W'(1))
                                       + COUNTDOWN_W'(extra);
                    end
                end
                CMD_GOTO, CMD_WAIT, CMD_SPEED, CMD_CAL:
                begin
                    if (fifo_full)
                    begin
                        rejected = 1'b1;
                    end
                    else
                    begin
                        fifo_ctl.push = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (cfg_we)
        begin
            period_next = cfg_period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_CAL;
            pos_reg       <= '0;
            target_reg    <= '0;
            period_reg    <= PERIOD_RESET;
            countdown_reg <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            target_reg    <= target_next;
            period_reg    <= period_next;
            countdown_reg <= countdown_next;
        end
    end

    assign result.step     = step;
    assign result.position = POS_OUT_W'(48'(pos_next));
    assign result.mode     = mode_next;
    assign result.rejected = rejected;
    assign result.level    = LEVEL_W'(level_next);

endmodule

FILE: rtl/core/stepper_position_controller.sv
// Top level of the stepper position controller: input and result registers
// around the controller. Depends on spc_pkg, spc_ctrl (which holds spc_fifo).
`timescale 1ns / 1ps

// Usage
// - s_* channel: one item per handshake. s_tuser is the item kind: a tick
//   (advances the pace countdown, maybe one controller step) or the push of
//   a goto / wait / speed / calibrate command into an 8-deep (QUEUE_DEPTH)
//   command queue. A push to a full queue is dropped and flagged.
// - m_* channel: exactly one result item per input item, in order: step
//   issued, position, mode, dropped-push flag and queue level after the item.
// - cfg_* channel: writes the step period; always ready. Write only while
//   no item is in flight.
// Flow: an accepted item sits in the input register and is loaded into the
// result register once that may load, which raises m_tvalid. Throughput:
// 1 item per cycle while m_tready keeps up; the whole update is one pass of
// short logic, bounded by the position compare and countdown reload.
// Reset: mode calibrating, position and target 0, step period 20, pace
// countdown 0, queue empty. No clearing pass; queue slots are never used
// before written.
// Stall: while m_tready is low the result register holds; one more item is
// taken into the input register, after which s_tready drops.
module stepper_position_controller #(
    parameter int QUEUE_DEPTH   = spc_pkg::QUEUE_DEPTH_DEF,
    parameter int POSITION_BITS = spc_pkg::POSITION_BITS_DEF,
    parameter int WAIT_BITS     = spc_pkg::WAIT_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input items
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,  // [15:0] value, [16] detector_active,
                                                   // rest 0
    input  logic [spc_pkg::CMD_W-1:0]    s_tuser,  // [2:0] cmd
    // result items
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,  // [1:0] step, [17:2] position,
                                                   // [19:18] mode, [20] push_rejected,
                                                   // [24:21] queue_level, rest 0
    // step period register
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [spc_pkg::PERIOD_W-1:0] cfg_data
);
    import spc_pkg::*;

    logic               in_valid_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               det_reg;

    logic               out_valid_reg;
    spc_result_t        result_reg;
    spc_result_t        result;

    logic advance;   // result register may load
    logic fire;      // item in the input register is processed this cycle

    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    spc_ctrl #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .POSITION_BITS(POSITION_BITS),
        .WAIT_BITS    (WAIT_BITS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .cmd            (cmd_reg),
        .value          (value_reg),
        .detector_active(det_reg),
        .cfg_we         (cfg_valid),
        .cfg_period     (cfg_data),
        .result         (result)
    );

    // handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg   <= s_tuser;
            value_reg <= s_tdata[VALUE_W-1:0];
            det_reg   <= s_tdata[VALUE_W];
        end
        if (fire)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, result_reg.level, result_reg.rejected, result_reg.mode,
                       result_reg.position, result_reg.step};

endmodule

FILE: rtl/core/spc_checker.sv
// Port-level checks on the result channel of the stepper position controller,
// bound to the top level. Depends on spc_pkg.
`timescale 1ns / 1ps

module spc_checker #(
    parameter int QUEUE_DEPTH = spc_pkg::QUEUE_DEPTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import spc_pkg::*;

    logic [STEP_W-1:0]  step;
    logic [1:0]         mode;
    logic               rejected;
    logic [LEVEL_W-1:0] level;

    assign step     = m_tdata[1:0];
    assign mode     = m_tdata[19:18];
    assign rejected = m_tdata[20];
    assign level    = m_tdata[24:21];

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // steps come from ticks, drops from pushes
    a_step_or_drop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (step != STEP_NONE) |-> !rejected)
        else $error("step and dropped push in one item");

    // a drop only happens against a full queue
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && rejected |-> level == LEVEL_W'(QUEUE_DEPTH))
        else $error("push dropped with room in queue");

    // right steps only while moving
    a_right_moving: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (step == STEP_RIGHT) |-> mode == MODE_MOVE)
        else $error("right step outside move");

    // no left step while idle
    a_left_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (step == STEP_LEFT) |-> mode != MODE_IDLE)
        else $error("left step while idle");

endmodule

bind stepper_position_controller spc_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_spc_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
